[design/tick_process_scheduler_unit_defines.svh]
// Assertion macros for the tick process scheduler
`ifndef TICK_PROCESS_SCHEDULER_UNIT_DEFINES_SVH
`define TICK_PROCESS_SCHEDULER_UNIT_DEFINES_SVH
// implication checked every clock edge, reset masks it
`define TPS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define TPS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[design/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the tick process scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;
	localparam int MAX_PROCS = 16;
	localparam int TIME_BITS = 20;
	localparam int SLOT_BITS = $clog2(MAX_PROCS);
	localparam int CNT_BITS  = SLOT_BITS + 1;
	localparam int TICK_BITS = TIME_BITS + 1;
	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
	localparam logic [15:0] QUANTUM_RESET = 16'd500;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_SJF  = 2'd2;
	localparam logic [1:0] POL_PSJF = 2'd3;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_QUANT  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RETIRE, ST_SCAN, ST_PICK, ST_POP, ST_FINISH
	} state_t;
endpackage

[design/tick_process_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tick_process_scheduler_unit
// Single-CPU scheduler: table load and per-tick retire, arrive, pick, advance.
// ----------------------------------------------------------------------------
// Load: no result. Tick: the result strobe follows the retire state, a scan of the n
// active entries through the table memories one entry a cycle, and the pick,
// write-back and result stages; busy until the strobe, so the next transfer is not
// taken before it. A tick that completes the set or finds it complete strobes
// right after its retire state, with no scan.
// The receiver cannot stall; arst_n clears control state, memories hold no reset.
`include "tick_process_scheduler_unit_defines.svh"
module tick_process_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [3:0]  slot,
	input  logic [19:0] arrival_time,
	input  logic [19:0] run_time,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        running_valid,
	output logic [3:0]  running_slot,
	output logic        switched,
	output logic        finished_valid,
	output logic [3:0]  finished_slot,
	output logic        all_done,
	output logic [20:0] time_now
);
	localparam int SB = tps_pkg::SLOT_BITS;
	localparam int CB = tps_pkg::CNT_BITS;
	localparam int TB = tps_pkg::TIME_BITS;
	localparam int KB = tps_pkg::TICK_BITS;

	logic [TB-1:0] arr_mem [tps_pkg::MAX_PROCS];
	logic [TB-1:0] rem_mem [tps_pkg::MAX_PROCS];
	logic [SB-1:0] ring_mem [tps_pkg::MAX_PROCS];

	logic [1:0]  policy_q;
	logic [CB-1:0] pcount_q;
	logic [15:0] quantum_q;
	logic [tps_pkg::MAX_PROCS-1:0] arrived_q;
	logic [SB-1:0] head_q;
	logic [CB-1:0] rcount_q;
	logic        cur_v_q;
	logic [SB-1:0] cur_q;
	logic [KB-1:0] tick_q, lsw_q;
	logic [CB-1:0] fin_cnt_q;
	tps_pkg::state_t state_q, state_d;
	logic [CB-1:0] idx_q;
	logic          rd_v_s1;
	logic [SB-1:0] rd_idx_s1;
	logic [TB-1:0] arr_rd_s1, rem_rd_s1;
	logic [SB-1:0] ring_rd_q;
	logic          best_v_q;
	logic [SB-1:0] best_q;
	logic [TB-1:0] best_rem_q;
	logic          fifo_v_q;
	logic [SB-1:0] fifo_q;
	logic          fv_q;
	logic [SB-1:0] fs_q;

	// memory port
	logic          mem_we;
	logic [SB-1:0] mem_wa, mem_ra;
	logic [TB-1:0] arr_wd, rem_wd;
	logic          ring_we;
	logic [SB-1:0] ring_wa;
	logic [SB-1:0] ring_wd;

	// next runner slot by policy; for rr the popped ring head
	logic          nx_v;
	logic [SB-1:0] nx;

	logic [CB-1:0] n_act;
	always_comb begin
		if (pcount_q == '0) n_act = CB'(1);
		else if (32'(pcount_q) > tps_pkg::MAX_PROCS) n_act = CB'(tps_pkg::MAX_PROCS);
		else n_act = pcount_q;
	end

	assign busy = (state_q != tps_pkg::ST_IDLE);
	wire accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= tps_pkg::POL_FIFO;
			pcount_q  <= CB'(1);
			quantum_q <= tps_pkg::QUANTUM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tps_pkg::REG_POLICY: policy_q  <= cfg_data[1:0];
				tps_pkg::REG_COUNT:  pcount_q  <= cfg_data[CB-1:0];
				tps_pkg::REG_QUANT:  quantum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			arr_mem[mem_wa] <= arr_wd;
			rem_mem[mem_wa] <= rem_wd;
		end
		arr_rd_s1 <= arr_mem[mem_ra];
		rem_rd_s1 <= rem_mem[mem_ra];
		if (ring_we) ring_mem[ring_wa] <= ring_wd;
		ring_rd_q <= ring_mem[head_q];
	end

	wire ready_s1 = arrived_q[rd_idx_s1] || (arr_rd_s1 == tick_q[TB-1:0] && !tick_q[KB-1]);
	wire rr_pre = !cur_v_q || ((tick_q - lsw_q) >= KB'(quantum_q));
	wire full_done = fin_cnt_q >= n_act;
	wire retire_hit = cur_v_q && rem_rd_s1 == '0;
	wire last_fin = retire_hit && (fin_cnt_q + CB'(1) >= n_act);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0; mem_wa = cur_q; arr_wd = arrival_time; rem_wd = run_time;
		mem_ra = idx_q[SB-1:0];
		ring_we = 1'b0; ring_wa = head_q + rcount_q[SB-1:0]; ring_wd = rd_idx_s1;
		case (state_q)
			tps_pkg::ST_IDLE: begin
				mem_ra = cur_q;
				if (accept && !operation) begin
					mem_we = 1'b1; mem_wa = slot;
				end else if (accept) state_d = tps_pkg::ST_RETIRE;
			end
			tps_pkg::ST_RETIRE: begin
				if (full_done || last_fin) state_d = tps_pkg::ST_IDLE;
				else state_d = tps_pkg::ST_SCAN;
			end
			tps_pkg::ST_SCAN: begin
				if (rd_v_s1 && arr_rd_s1 == tick_q[TB-1:0] && !tick_q[KB-1]
				    && rcount_q < CB'(tps_pkg::MAX_PROCS)) ring_we = 1'b1;
				if (!rd_v_s1 && idx_q >= n_act) state_d = tps_pkg::ST_PICK;
			end
			tps_pkg::ST_PICK: begin
				state_d = tps_pkg::ST_POP;
				// fetch the new runner's entry for the write-back
				mem_ra = nx;
				if (policy_q == tps_pkg::POL_RR && rr_pre && rcount_q != '0 && cur_v_q) begin
					ring_we = 1'b1; ring_wa = head_q + rcount_q[SB-1:0]; ring_wd = cur_q;
				end
			end
			tps_pkg::ST_POP: begin
				state_d = tps_pkg::ST_FINISH;
				mem_we = cur_v_q && rem_rd_s1 != '0;
				mem_wa = cur_q;
				arr_wd = arr_rd_s1;
				rem_wd = rem_rd_s1 - TB'(1);
			end
			tps_pkg::ST_FINISH: state_d = tps_pkg::ST_IDLE;
			default: state_d = tps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		nx_v = cur_v_q; nx = cur_q;
		case (policy_q)
			tps_pkg::POL_FIFO: if (!cur_v_q) begin nx_v = fifo_v_q; nx = fifo_q; end
			tps_pkg::POL_RR: if (rr_pre && rcount_q != '0) begin nx_v = 1'b1; nx = ring_rd_q; end
			tps_pkg::POL_SJF: if (!cur_v_q) begin nx_v = best_v_q; nx = best_q; end
			default: if (best_v_q) begin nx_v = 1'b1; nx = best_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tps_pkg::ST_IDLE;
			arrived_q <= '0; head_q <= '0; rcount_q <= '0;
			cur_v_q <= 1'b0; cur_q <= '0; tick_q <= '0; lsw_q <= '0;
			fin_cnt_q <= '0; idx_q <= '0; rd_v_s1 <= 1'b0; rd_idx_s1 <= '0;
			best_v_q <= 1'b0; best_q <= '0; best_rem_q <= '0;
			fifo_v_q <= 1'b0; fifo_q <= '0; fv_q <= 1'b0; fs_q <= '0;
			done <= 1'b0;
			running_valid <= 1'b0; running_slot <= '0; switched <= 1'b0;
			finished_valid <= 1'b0; finished_slot <= '0; all_done <= 1'b0; time_now <= '0;
		end else begin
			state_q <= state_d;
			done <= (state_q == tps_pkg::ST_FINISH) ||
				(state_q == tps_pkg::ST_RETIRE && state_d == tps_pkg::ST_IDLE);
			case (state_q)
				tps_pkg::ST_IDLE: if (state_d == tps_pkg::ST_RETIRE) begin
					idx_q <= '0; rd_v_s1 <= 1'b0;
					best_v_q <= 1'b0; fifo_v_q <= 1'b0; fv_q <= 1'b0; fs_q <= '0;
				end
				tps_pkg::ST_RETIRE: begin
					if (full_done) begin
						{running_valid, switched, finished_valid} <= '0;
						running_slot <= '0; finished_slot <= '0;
						all_done <= 1'b1; time_now <= tick_q;
					end else if (retire_hit) begin
						fv_q <= 1'b1; fs_q <= cur_q; cur_v_q <= 1'b0;
						fin_cnt_q <= fin_cnt_q + CB'(1);
						if (last_fin) begin
							{running_valid, switched} <= '0; running_slot <= '0;
							finished_valid <= 1'b1; finished_slot <= cur_q;
							all_done <= 1'b1; time_now <= tick_q;
						end
					end
				end
				tps_pkg::ST_SCAN: begin
					if (idx_q < n_act) idx_q <= idx_q + CB'(1);
					rd_v_s1 <= idx_q < n_act; rd_idx_s1 <= idx_q[SB-1:0];
					if (rd_v_s1) begin
						if (arr_rd_s1 == tick_q[TB-1:0] && !tick_q[KB-1]) begin
							arrived_q[rd_idx_s1] <= 1'b1;
							if (rcount_q < CB'(tps_pkg::MAX_PROCS)) rcount_q <= rcount_q + CB'(1);
						end
						if (ready_s1 && rem_rd_s1 != '0) begin
							if (!fifo_v_q) begin fifo_v_q <= 1'b1; fifo_q <= rd_idx_s1; end
							if (!best_v_q || rem_rd_s1 < best_rem_q) begin
								best_v_q <= 1'b1; best_q <= rd_idx_s1; best_rem_q <= rem_rd_s1;
							end
						end
					end
				end
				tps_pkg::ST_PICK: begin
					if (policy_q == tps_pkg::POL_RR && rr_pre && rcount_q != '0) begin
						head_q <= head_q + SB'(1);
						if (!cur_v_q) rcount_q <= rcount_q - CB'(1);
					end
					switched <= nx_v && (!cur_v_q || nx != cur_q);
					if (nx_v && (!cur_v_q || nx != cur_q)) lsw_q <= tick_q;
					cur_v_q <= nx_v; cur_q <= nx;
				end
				tps_pkg::ST_FINISH: begin
					running_valid <= cur_v_q; running_slot <= cur_v_q ? cur_q : '0;
					finished_valid <= fv_q; finished_slot <= fs_q;
					all_done <= 1'b0; time_now <= tick_q;
					if (tick_q != tps_pkg::TICK_MAX) tick_q <= tick_q + KB'(1);
				end
				default: ;
			endcase
		end
	end

	`TPS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`TPS_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held too long")
	`TPS_ASSERT_NXT(a_tick_busy, clk, arst_n, start && !busy && operation, busy, "tick not taken")
	`TPS_ASSERT_IMP(a_ring_cap, clk, arst_n, 1'b1, rcount_q <= CB'(tps_pkg::MAX_PROCS), "ring over")
	`TPS_ASSERT_IMP(a_idle_slot, clk, arst_n, done && !running_valid, running_slot == '0, "idle slot")
endmodule
